// ===== rtl/frame_buffer_pool_allocator_defines.svh =====
// Assertion macros for the frame buffer pool allocator checker.
`ifndef FRAME_BUFFER_POOL_ALLOCATOR_DEFINES_SVH
`define FRAME_BUFFER_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define FPA_ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define FPA_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/fpa_pkg.sv =====
// Shared types and constants of the frame buffer pool allocator.
package fpa_pkg;

  // Width of entry indexes and of the buffer count.
  localparam int IDX_W    = 4;
  localparam int REQ_ID_W = 16;
  localparam int CFG_W    = 4;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 8;

  // Input word layout.
  localparam int S_MODE_LSB  = 0;
  localparam int S_ID_LSB    = 2;
  localparam int S_MAIN_BIT  = 18;
  localparam int S_INDEX_LSB = 19;

  // Result word layout.
  localparam int OUT_GRANTED_BIT = 0;
  localparam int OUT_DEVICE_BIT  = 5;
  localparam int OUT_READY_BIT   = 6;

  // Request codes.
  localparam logic [1:0] MODE_ACQUIRE = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_MARK    = 2'd2;

  // Entry status codes.
  localparam logic [1:0] ENT_FREE = 2'd0;
  localparam logic [1:0] ENT_MAIN = 2'd1;
  localparam logic [1:0] ENT_PREP = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_WRITE
  } state_t;

  // Memory port controls.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear_all;
  } mem_cmd_t;

  // One result word; granted sits in the lowest bit.
  typedef struct packed {
    logic             content_ready;
    logic             is_device_buffer;
    logic [IDX_W-1:0] granted_index;
    logic             granted;
  } result_t;

endpackage

// ===== rtl/fpa_mem.sv =====
// Entry table memory: one write port, one registered read port, per-entry valid bits.
module fpa_mem #(
  parameter int ENTRIES = 16,
  parameter int ID_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fpa_pkg::mem_cmd_t            cmd,
  input  logic [$clog2(ENTRIES)-1:0]   rd_addr,
  input  logic [$clog2(ENTRIES)-1:0]   wr_addr,
  input  logic [ID_BITS+2:0]           wr_data,
  output logic [ID_BITS+2:0]           rd_data
);

  localparam int DW = ID_BITS + 3;

  logic [DW-1:0]      mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [DW-1:0]      rd_q;
  logic               rd_valid;

  // Storage array and its registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // An entry that was never written since the last clear reads as all zero.
  // A clear keeps only the entry that is written in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.clear_all) begin
        valid <= cmd.wr_en ? (ENTRIES'(1) << wr_addr) : '0;
      end else if (cmd.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

// ===== rtl/fpa_ctrl.sv =====
// Request sequencer: scans the entry table, picks an entry, writes it back and issues the result.
module fpa_ctrl #(
  parameter int ENTRIES = 16,
  parameter int ID_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [fpa_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               s_valid,
  output logic                               s_ready,
  input  logic [1:0]                         mode,
  input  logic signed [fpa_pkg::REQ_ID_W-1:0] request_id,
  input  logic                               for_main,
  input  logic [fpa_pkg::IDX_W-1:0]          buffer_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fpa_pkg::result_t                   out_res,
  output fpa_pkg::mem_cmd_t                  mem_cmd,
  output logic [$clog2(ENTRIES)-1:0]         rd_addr,
  output logic [$clog2(ENTRIES)-1:0]         wr_addr,
  output logic [ID_BITS+2:0]                 wr_data,
  input  logic [ID_BITS+2:0]                 rd_data
);

  localparam int AW    = $clog2(ENTRIES);
  localparam int IW    = fpa_pkg::IDX_W;
  localparam int MAX_I = (ENTRIES - 1 > 15) ? 15 : ENTRIES - 1;
  localparam logic [IW-1:0] MAX_COUNT = IW'(MAX_I);

  fpa_pkg::state_t state, state_next;

  logic [IW-1:0]      count;
  logic [IW-1:0]      cfg_count;
  logic [1:0]         req_mode;
  logic [ID_BITS-1:0] req_id;
  logic               req_main;
  logic [IW-1:0]      req_idx;
  logic               idx_ok;
  logic [IW-1:0]      scan_idx;
  logic [IW-1:0]      end_idx;
  logic               rd_pend;
  logic [IW-1:0]      rd_idx;

  // Candidates found during the scan.
  logic               f_id, f_blank, f_any;
  logic [IW-1:0]      id_idx, blank_idx, any_idx;
  logic               id_filled;

  // Entry captured for release and mark.
  logic [1:0]         ent_status;
  logic [ID_BITS-1:0] ent_id;
  logic               ent_filled;

  // Fields of the entry now on the read port.
  logic [1:0]         rd_status;
  logic [ID_BITS-1:0] rd_id;
  logic               rd_filled;
  logic               rd_free;

  // Write-back decision.
  logic               do_write;
  logic [IW-1:0]      wr_idx;
  logic [1:0]         wr_status;
  logic [ID_BITS-1:0] wr_id;
  logic               wr_filled;
  fpa_pkg::result_t   res;

  logic               accept;
  logic               finish;
  logic               req_idx_ok;

  assign rd_status = rd_data[ID_BITS+2 -: 2];
  assign rd_id     = rd_data[1 +: ID_BITS];
  assign rd_filled = rd_data[0];
  assign rd_free   = (rd_status == fpa_pkg::ENT_FREE);

  // The count is limited to the last entry of the pool.
  assign cfg_count  = (cfg_data > MAX_COUNT) ? MAX_COUNT : cfg_data;

  assign s_ready    = (state == fpa_pkg::S_IDLE);
  assign accept     = s_valid && s_ready;
  assign finish     = (state == fpa_pkg::S_WRITE) && (!out_valid || out_ready);
  assign req_idx_ok = (buffer_index <= count);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fpa_pkg::S_IDLE: begin
        if (s_valid) begin
          if (mode == fpa_pkg::MODE_ACQUIRE ||
              ((mode == fpa_pkg::MODE_RELEASE || mode == fpa_pkg::MODE_MARK) && req_idx_ok)) begin
            state_next = fpa_pkg::S_SCAN;
          end else begin
            state_next = fpa_pkg::S_WRITE;
          end
        end
      end
      fpa_pkg::S_SCAN: begin
        if (scan_idx == end_idx) begin
          state_next = fpa_pkg::S_LAST;
        end
      end
      fpa_pkg::S_LAST: begin
        state_next = fpa_pkg::S_WRITE;
      end
      fpa_pkg::S_WRITE: begin
        if (!out_valid || out_ready) begin
          state_next = fpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fpa_pkg::S_IDLE;
      end
    endcase
  end

  // Pick the entry to write back and form the result.
  always_comb begin
    res       = '0;
    do_write  = 1'b0;
    wr_idx    = req_idx;
    wr_status = fpa_pkg::ENT_FREE;
    wr_id     = req_id;
    wr_filled = 1'b0;
    unique case (req_mode)
      fpa_pkg::MODE_ACQUIRE: begin
        wr_status = req_main ? fpa_pkg::ENT_MAIN : fpa_pkg::ENT_PREP;
        priority if (f_id) begin
          do_write  = 1'b1;
          wr_idx    = id_idx;
          wr_filled = id_filled;
        end else if (f_blank) begin
          do_write = 1'b1;
          wr_idx   = blank_idx;
        end else if (f_any) begin
          do_write = 1'b1;
          wr_idx   = any_idx;
        end else if (req_main) begin
          do_write = 1'b1;
          wr_idx   = '0;
        end else begin
          do_write = 1'b0;
        end
        res.granted          = do_write;
        res.granted_index    = do_write ? wr_idx : '0;
        res.is_device_buffer = do_write && (wr_idx == count);
        res.content_ready    = do_write && wr_filled;
      end
      fpa_pkg::MODE_RELEASE: begin
        res.granted_index = req_idx;
        if (idx_ok) begin
          do_write             = 1'b1;
          wr_id                = ent_id;
          wr_filled            = ent_filled && (ent_id != '1);
          res.granted          = 1'b1;
          res.is_device_buffer = (req_idx == count);
          res.content_ready    = wr_filled;
        end
      end
      fpa_pkg::MODE_MARK: begin
        res.granted_index = req_idx;
        if (idx_ok) begin
          do_write             = 1'b1;
          wr_status            = ent_status;
          wr_id                = ent_id;
          wr_filled            = 1'b1;
          res.granted          = 1'b1;
          res.is_device_buffer = (req_idx == count);
          res.content_ready    = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Memory port drive; a configuration write clears the table and marks the device entry when the count is nonzero.
  always_comb begin
    mem_cmd.rd_en     = (state == fpa_pkg::S_SCAN);
    mem_cmd.clear_all = cfg_valid;
    rd_addr           = AW'(scan_idx);
    if (cfg_valid) begin
      mem_cmd.wr_en = (cfg_count != '0);
      wr_addr       = AW'(cfg_count);
      wr_data       = {fpa_pkg::ENT_MAIN, {ID_BITS{1'b0}}, 1'b0};
    end else begin
      mem_cmd.wr_en = (state == fpa_pkg::S_WRITE) && do_write;
      wr_addr       = AW'(wr_idx);
      wr_data       = {wr_status, wr_id, wr_filled};
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fpa_pkg::S_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == fpa_pkg::S_SCAN);
      if (cfg_valid) begin
        count <= cfg_count;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request, scan and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= mode;
      req_id   <= ID_BITS'(request_id);
      req_main <= for_main;
      req_idx  <= buffer_index;
      idx_ok   <= req_idx_ok;
      scan_idx <= (mode == fpa_pkg::MODE_ACQUIRE) ? '0 : buffer_index;
      end_idx  <= (mode == fpa_pkg::MODE_ACQUIRE) ? count : buffer_index;
      f_id     <= 1'b0;
      f_blank  <= 1'b0;
      f_any    <= 1'b0;
    end
    if (state == fpa_pkg::S_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
      rd_idx   <= scan_idx;
    end
    // Keep the first free entry of each kind in scan order.
    if (rd_pend) begin
      ent_status <= rd_status;
      ent_id     <= rd_id;
      ent_filled <= rd_filled;
      if (rd_free && (rd_id == req_id) && !f_id) begin
        f_id      <= 1'b1;
        id_idx    <= rd_idx;
        id_filled <= rd_filled;
      end
      if (rd_free && !rd_filled && !f_blank) begin
        f_blank   <= 1'b1;
        blank_idx <= rd_idx;
      end
      if (rd_free && !f_any) begin
        f_any   <= 1'b1;
        any_idx <= rd_idx;
      end
    end
    if (finish) begin
      out_res <= res;
    end
  end

endmodule

// ===== rtl/frame_buffer_pool_allocator.sv =====
// Top level of the frame buffer pool allocator.
//
// Requests arrive as words on the s_ channel (acquire, release, mark filled) and each
// request gives exactly one result word on the m_ channel. The cfg channel writes the
// number of off-screen buffers; each write reinitializes the pool, and entry count then
// holds the device buffer, busy for main display when the count is nonzero.
// An acquire scans entries 0 to count one per cycle through the table's read port; its
// result rises on m_tvalid together with s_tready, and no new request is accepted
// before then. Release and mark read only their own entry; an index past the device
// entry or an unused code skips the table and goes straight to the write-back state.
// A new request is accepted while the previous result still waits in the output
// register; if the receiver stalls longer, the block holds its next result and stops
// accepting until the output register frees up.
// Reset sets the count to zero and marks every table entry as never written, which
// reads as free, blank and tagged zero. Configuration writes are always taken.
module frame_buffer_pool_allocator #(
  parameter int POOL_ENTRIES = 16,
  parameter int ID_BITS      = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // Requests: mode[1:0], request_id[17:2], for_main[18], buffer_index[22:19], zero[23].
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [fpa_pkg::S_DATA_W-1:0]   s_tdata,
  // Results: granted[0], granted_index[4:1], is_device_buffer[5], content_ready[6], zero[7].
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [fpa_pkg::M_DATA_W-1:0]   m_tdata,
  // Configuration: buffers_in_use[3:0].
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fpa_pkg::CFG_W-1:0]      cfg_data
);

  localparam int AW = $clog2(POOL_ENTRIES);

  logic [1:0]                          mode;
  logic signed [fpa_pkg::REQ_ID_W-1:0] request_id;
  logic                                for_main;
  logic [fpa_pkg::IDX_W-1:0]           buffer_index;
  fpa_pkg::result_t                    res;
  fpa_pkg::mem_cmd_t                   mem_cmd;
  logic [AW-1:0]                       rd_addr;
  logic [AW-1:0]                       wr_addr;
  logic [ID_BITS+2:0]                  wr_data;
  logic [ID_BITS+2:0]                  rd_data;

  // Unpack the request word.
  assign mode         = s_tdata[fpa_pkg::S_MODE_LSB +: 2];
  assign request_id   = s_tdata[fpa_pkg::S_ID_LSB +: fpa_pkg::REQ_ID_W];
  assign for_main     = s_tdata[fpa_pkg::S_MAIN_BIT];
  assign buffer_index = s_tdata[fpa_pkg::S_INDEX_LSB +: fpa_pkg::IDX_W];

  // Configuration is taken in any cycle.
  assign cfg_ready = 1'b1;

  // Pack the result word.
  assign m_tdata = fpa_pkg::M_DATA_W'(res);

  fpa_ctrl #(
    .ENTRIES (POOL_ENTRIES),
    .ID_BITS (ID_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .s_valid      (s_tvalid),
    .s_ready      (s_tready),
    .mode         (mode),
    .request_id   (request_id),
    .for_main     (for_main),
    .buffer_index (buffer_index),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_res      (res),
    .mem_cmd      (mem_cmd),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_data      (rd_data)
  );

  fpa_mem #(
    .ENTRIES (POOL_ENTRIES),
    .ID_BITS (ID_BITS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mem_cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule

// ===== rtl/fpa_checker.sv =====
// Port-level checker of the frame buffer pool allocator and its bind.
`include "frame_buffer_pool_allocator_defines.svh"

module fpa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [fpa_pkg::M_DATA_W-1:0] m_tdata
);

  // A stalled result word holds.
  `FPA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // Only one request is in work at a time.
  `FPA_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready, "request accepted while busy")

  // A refused request reports neither the device buffer nor content.
  `FPA_ASSERT_IMPLY(a_refused_clean, m_tvalid && !m_tdata[fpa_pkg::OUT_GRANTED_BIT], !m_tdata[fpa_pkg::OUT_DEVICE_BIT] && !m_tdata[fpa_pkg::OUT_READY_BIT], "refused result has flags set")

  // The device buffer is only reported on a granted request.
  `FPA_ASSERT_IMPLY(a_device_granted, m_tvalid && m_tdata[fpa_pkg::OUT_DEVICE_BIT], m_tdata[fpa_pkg::OUT_GRANTED_BIT], "device flag without grant")

endmodule

bind frame_buffer_pool_allocator fpa_checker u_fpa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/frame_buffer_pool_allocator_tb.sv =====
// Self-checking testbench for the frame buffer pool allocator.
module frame_buffer_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code that the block must ignore.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int POOL_DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRESSURE_CYCLES = 400;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_REQUESTS = 160;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] id;
    logic        for_main;
    logic [3:0]  index;
  } pool_request_t;

  // Tracks the pool as the block should see it and keeps the grants still owed.
  class grant_scoreboard;
    int unsigned       pool_size;
    logic [1:0]        status[POOL_DEPTH];
    logic [15:0]       tag[POOL_DEPTH];
    bit                filled[POOL_DEPTH];
    fpa_pkg::result_t  pending_grants[$];
    int                mismatches;
    int                refused;
    int                forced;
    int                device_grants;

    function new();
      set_pool_size(0);
    endfunction

    // A write of the count clears the pool; the device entry is busy unless the count is zero.
    function void set_pool_size(int unsigned n);
      pool_size = n;
      foreach (status[i]) begin
        status[i] = fpa_pkg::ENT_FREE;
        tag[i] = '0;
        filled[i] = 1'b0;
      end
      if (n != 0) status[n] = fpa_pkg::ENT_MAIN;
    endfunction

    // First free entry in scan order: rule 0 wants a matching tag, 1 a blank entry, 2 any.
    function int first_free(int rule, logic [15:0] id);
      for (int i = 0; i <= pool_size; i++) begin
        if (status[i] == fpa_pkg::ENT_FREE &&
            (rule == 2 || (rule == 1 && !filled[i]) || (rule == 0 && tag[i] == id)))
          return i;
      end
      return -1;
    endfunction

    function fpa_pkg::result_t grant_for(pool_request_t req);
      fpa_pkg::result_t r;
      logic [1:0]       busy_code;
      int               where;
      r = '0;
      busy_code = req.for_main ? fpa_pkg::ENT_MAIN : fpa_pkg::ENT_PREP;
      if (req.mode == fpa_pkg::MODE_ACQUIRE) begin
        where = first_free(0, req.id);
        if (where < 0) begin
          where = first_free(1, req.id);
          if (where < 0) begin
            where = first_free(2, req.id);
            if (where < 0 && req.for_main) begin
              where = 0;
              forced++;
            end
            if (where >= 0) filled[where] = 1'b0;
          end
          if (where >= 0) tag[where] = req.id;
        end
        if (where >= 0) begin
          status[where] = busy_code;
          r.granted = 1'b1;
          r.granted_index = 4'(where);
          r.is_device_buffer = (where == pool_size);
          r.content_ready = filled[where];
          if (where == pool_size) device_grants++;
        end else begin
          refused++;
        end
      end else if (req.mode == fpa_pkg::MODE_RELEASE || req.mode == fpa_pkg::MODE_MARK) begin
        r.granted_index = req.index;
        if (req.index <= pool_size) begin
          if (req.mode == fpa_pkg::MODE_RELEASE) begin
            status[req.index] = fpa_pkg::ENT_FREE;
            if (tag[req.index] == 16'hFFFF) filled[req.index] = 1'b0;
          end else begin
            filled[req.index] = 1'b1;
          end
          r.granted = 1'b1;
          r.is_device_buffer = (req.index == pool_size);
          r.content_ready = filled[req.index];
        end
      end
      return r;
    endfunction

    function void note_request(pool_request_t req);
      pending_grants.push_back(grant_for(req));
    endfunction

    function void check_grant(logic [fpa_pkg::M_DATA_W-1:0] word);
      fpa_pkg::result_t got;
      fpa_pkg::result_t want;
      got = word[$bits(fpa_pkg::result_t)-1:0];
      if (pending_grants.size() == 0) begin
        $error("result word %h arrived with no request outstanding", word);
        mismatches++;
        return;
      end
      want = pending_grants.pop_front();
      if (got.granted !== want.granted) begin
        $error("granted: expected %0d, got %0d", want.granted, got.granted);
        mismatches++;
      end
      if (got.granted_index !== want.granted_index) begin
        $error("granted_index: expected %0d, got %0d", want.granted_index, got.granted_index);
        mismatches++;
      end
      if (got.is_device_buffer !== want.is_device_buffer) begin
        $error("is_device_buffer: expected %0d, got %0d",
               want.is_device_buffer, got.is_device_buffer);
        mismatches++;
      end
      if (got.content_ready !== want.content_ready) begin
        $error("content_ready: expected %0d, got %0d", want.content_ready, got.content_ready);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [fpa_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [fpa_pkg::M_DATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fpa_pkg::CFG_W-1:0] cfg_data = '0;

  grant_scoreboard grants = new();
  int sender_pct = 0;
  int receiver_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int cur_count = 0;
  int requests_sent = 0;
  int sizes_written = 0;

  frame_buffer_pool_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_request;
      hold_request = 0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_pct);
    end
  end

  // Every result word is checked against the oldest outstanding grant.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) grants.check_grant(m_tdata);
  end

  // Watchdog on cycles in which no word moves on any channel.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic pool_request_t req_of(logic [1:0] mode, logic [15:0] id,
                                           logic for_main, logic [3:0] index);
    pool_request_t r;
    r.mode = mode;
    r.id = id;
    r.for_main = for_main;
    r.index = index;
    return r;
  endfunction

  function automatic logic [fpa_pkg::S_DATA_W-1:0] pack_request(pool_request_t r);
    logic [fpa_pkg::S_DATA_W-1:0] w;
    w = '0;
    w[fpa_pkg::S_MODE_LSB +: 2] = r.mode;
    w[fpa_pkg::S_ID_LSB +: fpa_pkg::REQ_ID_W] = r.id;
    w[fpa_pkg::S_MAIN_BIT] = r.for_main;
    w[fpa_pkg::S_INDEX_LSB +: fpa_pkg::IDX_W] = r.index;
    return w;
  endfunction

  // Small ids dominate so that tag matches and reuse happen often.
  function automatic pool_request_t random_request();
    pool_request_t r;
    int pick;
    pick = $urandom_range(99);
    r.mode = pick < 45 ? fpa_pkg::MODE_ACQUIRE : pick < 75 ? fpa_pkg::MODE_RELEASE :
             pick < 95 ? fpa_pkg::MODE_MARK : MODE_UNUSED;
    pick = $urandom_range(99);
    if (pick < 12) r.id = 16'hFFFF;
    else if (pick < 85) r.id = 16'($urandom_range(7));
    else r.id = 16'($urandom);
    r.for_main = 1'($urandom);
    if (r.mode != fpa_pkg::MODE_ACQUIRE && $urandom_range(99) < 80)
      r.index = 4'($urandom_range(cur_count));
    else
      r.index = 4'($urandom);
    return r;
  endfunction

  // Offer one request word and book it once the block takes it.
  task automatic offer_request(input pool_request_t req);
    while (sender_pct != 0 && $urandom_range(99) < sender_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= pack_request(req);
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    grants.note_request(req);
    requests_sent++;
  endtask

  // Let every outstanding grant come back before touching the count.
  task automatic drain_grants();
    s_tvalid <= 1'b0;
    while (grants.pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic write_pool_size(input int n);
    cfg_data <= fpa_pkg::CFG_W'(n);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    grants.set_pool_size(n);
    cur_count = n;
    sizes_written++;
  endtask

  initial begin
    pool_request_t directed[$];
    int size_plan[RANDOM_PHASES];

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed pass on a two-buffer pool: reuse by tag, blank reuse, retag and blank,
    // refused and forced acquires, device entry traffic, out-of-range and unused codes.
    write_pool_size(2);
    directed.push_back(req_of(fpa_pkg::MODE_ACQUIRE, 16'd5, 1'b1, 4'd0));
    directed.push_back(req_of(fpa_pkg::MODE_MARK, 16'd0, 1'b0, 4'd0));
    directed.push_back(req_of(fpa_pkg::MODE_RELEASE, 16'd0, 1'b0, 4'd0));
    directed.push_back(req_of(fpa_pkg::MODE_ACQUIRE, 16'd5, 1'b0, 4'd0));
    directed.push_back(req_of(fpa_pkg::MODE_ACQUIRE, 16'hFFFF, 1'b0, 4'd0));
    directed.push_back(req_of(fpa_pkg::MODE_MARK, 16'd0, 1'b0, 4'd1));
    directed.push_back(req_of(fpa_pkg::MODE_RELEASE, 16'd0, 1'b0, 4'd1));
    directed.push_back(req_of(fpa_pkg::MODE_ACQUIRE, 16'd0, 1'b0, 4'd0));
    directed.push_back(req_of(fpa_pkg::MODE_ACQUIRE, 16'd7, 1'b0, 4'd0));
    directed.push_back(req_of(fpa_pkg::MODE_ACQUIRE, 16'h7FFF, 1'b1, 4'd0));
    directed.push_back(req_of(fpa_pkg::MODE_MARK, 16'd0, 1'b0, 4'd2));
    directed.push_back(req_of(fpa_pkg::MODE_RELEASE, 16'd0, 1'b0, 4'd2));
    directed.push_back(req_of(fpa_pkg::MODE_ACQUIRE, 16'h8000, 1'b0, 4'd0));
    directed.push_back(req_of(fpa_pkg::MODE_MARK, 16'd0, 1'b0, 4'd15));
    directed.push_back(req_of(fpa_pkg::MODE_RELEASE, 16'd0, 1'b0, 4'd3));
    directed.push_back(req_of(MODE_UNUSED, 16'hFFFF, 1'b1, 4'd15));
    directed.push_back(req_of(fpa_pkg::MODE_RELEASE, 16'd0, 1'b0, 4'd0));
    directed.push_back(req_of(fpa_pkg::MODE_RELEASE, 16'd0, 1'b0, 4'd0));
    directed.push_back(req_of(fpa_pkg::MODE_ACQUIRE, 16'd1, 1'b1, 4'd15));
    foreach (directed[i]) offer_request(directed[i]);
    drain_grants();

    // Random phases over several pool sizes, the extremes included.
    size_plan = '{15, 0, 1, 7, 3, 15, 0, 5, 15, 1, 11, 15};
    size_plan[10] = $urandom_range(15);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_pool_size(size_plan[p]);
      if (p < 4) begin
        sender_pct = 18;
        receiver_pct = 60;
      end else if (p < 8) begin
        sender_pct = 60;
        receiver_pct = 18;
      end else begin
        sender_pct = 0;
        receiver_pct = 0;
      end
      // Long receiver hold-off while requests keep coming, to back up the block.
      if (p == 8) hold_request = PRESSURE_CYCLES;
      repeat (PHASE_REQUESTS) offer_request(random_request());
      drain_grants();
    end

    // Tail: catch any stray result after the last expected one.
    repeat (32) @(posedge clk);

    $display("Sent %0d requests over %0d pool size writes, with stalls on both sides.",
             requests_sent, sizes_written);
    $display("Refused acquires: %0d, forced main grants: %0d, device grants: %0d.",
             grants.refused, grants.forced, grants.device_grants);
    if (grants.mismatches == 0 && grants.pending_grants.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
